// ----- hdl/rbc_pkg.sv -----
// Shared types and constants for the radix converter.
package rbc_pkg;

  localparam int unsigned WORD_W     = 64;  // width of the incoming digit word
  localparam int unsigned DEC_DIGITS = 20;  // decimal digits of a 64-bit word
  localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
  localparam int unsigned CNT_W      = 7;   // shared step counter
  localparam int unsigned DIV_BITS   = 8;   // quotient bits per divider cycle
  localparam int unsigned MIN_BASE   = 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIGIT = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAME  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BCD,
    S_CHECK,
    S_HORNER,
    S_DIV,
    S_STORE,
    S_RD,
    S_LOAD,
    S_ERR
  } state_e;

  typedef struct packed {
    logic accept;
    logic bcd_shift;
    logic hor_init;
    logic hor_step;
    logic div_init;
    logic div_step;
    logic dig_store;
    logic rd_issue;
    logic out_digit;
    logic out_err;
  } cmd_t;

  typedef struct packed {
    logic bcd_last;
    logic hor_last;
    logic div_last;
    logic quot_zero;
    logic last_digit;
    logic out_free;
    logic err_any;
  } sts_t;

endpackage

// ----- hdl/radix_converter_base2_to_10_top.sv -----
// Top level of the radix converter: controller plus datapath.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  request | in_valid_i, in_ready_o, from_base_i,         | in
//          | to_base_i, digit_word_i                      |
//  result  | out_valid_o, out_ready_i, out_digit_o,       | out
//          | status_o, last_o                             |
//
// One request at a time. The word is split into BCD by a shift-and-add-three
// pass, checked, and accumulated by Horner's rule over 20 decimal digits.
// Each target digit then takes a pass of the 8-bit-per-cycle divider and a
// store step; the divider sets the bulk of the time. Read-back issues a stack
// read and then loads each digit into the output register once it is free.
// An error goes straight from the check to the result hand-off.
// Reset clears the controller, the step and digit counters and the output valid; nothing else needs it.
// A stalled result holds in the output register; the next request is taken
// while the final result of the previous one still waits.
module radix_converter_base2_to_10_top import rbc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_BASE    = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        from_base_i,
  input  logic [3:0]        to_base_i,
  input  logic [WORD_W-1:0] digit_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        out_digit_o,
  output logic [1:0]        status_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the phases: split, check, accumulate, divide, read back.
  rbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the request, the working value, the digit stack and the result register.
  rbc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_BASE    (MAX_BASE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .from_base_i  (from_base_i),
    .to_base_i    (to_base_i),
    .digit_word_i (digit_word_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_digit_o  (out_digit_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

// ----- hdl/rbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rbc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rbc_datapath.sv -----
// Datapath: BCD split, digit checks, Horner accumulate, divider, digit stack, output register.
module rbc_datapath import rbc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_BASE    = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [3:0]        from_base_i,
  input  logic [3:0]        to_base_i,
  input  logic [WORD_W-1:0] digit_word_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [3:0]        out_digit_o,
  output logic [1:0]        status_o,
  output logic              last_o
);

  localparam int unsigned DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned PAD_W     = DIV_STEPS * DIV_BITS;
  localparam int unsigned PROD_W    = VALUE_WIDTH + 4;
  localparam int unsigned AW        = $clog2(VALUE_WIDTH);
  localparam int unsigned NW        = $clog2(VALUE_WIDTH + 1);

  logic [3:0]        fb_q, tb_q;
  logic [WORD_W-1:0] word_q;
  logic [BCD_W-1:0]  bcd_q, bcd_adj;
  logic [PAD_W-1:0]  value_q, value_d;
  logic [3:0]        rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [NW-1:0]     n_q;
  logic              out_valid_q, out_last_q;
  logic [3:0]        out_digit_q;
  logic [1:0]        out_status_q;
  logic [PROD_W-1:0] hor_full;
  logic [DIV_BITS-1:0] quot_bits;
  logic [4:0]        trial;
  logic              digit_bad, base_bad;
  logic [1:0]        err_code;
  logic [3:0]        ram_rdata;
  logic [NW-1:0]     rd_idx;

  // Double dabble: add three to every digit of five or more before the shift.
  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                    : bcd_q[4*k +: 4];
    end
  end

  // Leading zero digits never trip the check for any base the real digits pass.
  always_comb begin
    digit_bad = 1'b0;
    for (int k = 0; k < DEC_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= fb_q) begin
        digit_bad = 1'b1;
      end
    end
  end

  assign base_bad = (fb_q < 4'(MIN_BASE)) || (fb_q > 4'(MAX_BASE)) ||
                    (tb_q < 4'(MIN_BASE)) || (tb_q > 4'(MAX_BASE));

  always_comb begin
    if (digit_bad) begin
      err_code = ST_DIGIT;
    end else if (base_bad) begin
      err_code = ST_RANGE;
    end else if (fb_q == tb_q) begin
      err_code = ST_SAME;
    end else begin
      err_code = ST_OK;
    end
  end

  assign hor_full = PROD_W'(value_q[VALUE_WIDTH-1:0]) * PROD_W'(fb_q)
                  + PROD_W'(bcd_q[BCD_W-1 -: 4]);

  // Restoring division by the target base, DIV_BITS quotient bits per cycle.
  always_comb begin
    rem_d = rem_q;
    trial = '0;
    quot_bits = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_d, value_q[PAD_W-1-i]};
      if (trial >= {1'b0, tb_q}) begin
        quot_bits[DIV_BITS-1-i] = 1'b1;
        trial = trial - {1'b0, tb_q};
      end
      rem_d = trial[3:0];
    end
  end

  always_comb begin
    value_d = value_q;
    if (cmd_i.hor_init) begin
      value_d = '0;
    end else if (cmd_i.hor_step) begin
      value_d = PAD_W'(hor_full[VALUE_WIDTH-1:0]);
    end else if (cmd_i.div_step) begin
      value_d = (value_q << DIV_BITS) | PAD_W'(quot_bits);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      fb_q   <= from_base_i;
      tb_q   <= to_base_i;
      word_q <= digit_word_i;
      bcd_q  <= '0;
    end else if (cmd_i.bcd_shift) begin
      bcd_q  <= {bcd_adj[BCD_W-2:0], word_q[WORD_W-1]};
      word_q <= word_q << 1;
    end else if (cmd_i.hor_step) begin
      bcd_q  <= bcd_q << 4;
    end
    value_q <= value_d;
    if (cmd_i.div_init || cmd_i.dig_store) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      n_q   <= '0;
    end else begin
      if (cmd_i.accept || cmd_i.hor_init || cmd_i.div_init || cmd_i.dig_store) begin
        cnt_q <= '0;
      end else if (cmd_i.bcd_shift || cmd_i.hor_step || cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.accept) begin
        n_q <= '0;
      end else if (cmd_i.dig_store) begin
        n_q <= n_q + 1'b1;
      end else if (cmd_i.rd_issue) begin
        n_q <= rd_idx;
      end
    end
  end

  assign rd_idx = n_q - 1'b1;

  // Target digits land least significant first and are read back in reverse.
  rbc_ram #(
    .WIDTH (4),
    .DEPTH (VALUE_WIDTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.dig_store),
    .waddr_i (n_q[AW-1:0]),
    .wdata_i (rem_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_digit || cmd_i.out_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_digit) begin
      out_digit_q  <= ram_rdata;
      out_status_q <= ST_OK;
      out_last_q   <= (n_q == '0);
    end else if (cmd_i.out_err) begin
      out_digit_q  <= '0;
      out_status_q <= err_code;
      out_last_q   <= 1'b1;
    end
  end

  assign sts_o.bcd_last   = (cnt_q == CNT_W'(WORD_W - 1));
  assign sts_o.hor_last   = (cnt_q == CNT_W'(DEC_DIGITS - 1));
  assign sts_o.div_last   = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign sts_o.quot_zero  = (value_q == '0);
  assign sts_o.last_digit = (n_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.err_any    = (err_code != ST_OK);

  assign out_valid_o = out_valid_q;
  assign out_digit_o = out_digit_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule

// ----- hdl/rbc_ctrl.sv -----
// Controller: sequences the conversion phases and the result hand-off.
module rbc_ctrl import rbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_BCD;
        end
      end
      S_BCD: begin
        cmd_o.bcd_shift = 1'b1;
        if (sts_i.bcd_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.err_any) begin
          state_d = S_ERR;
        end else begin
          cmd_o.hor_init = 1'b1;
          state_d        = S_HORNER;
        end
      end
      S_HORNER: begin
        cmd_o.hor_step = 1'b1;
        if (sts_i.hor_last) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.dig_store = 1'b1;
        state_d = sts_i.quot_zero ? S_RD : S_DIV;
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_LOAD;
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_digit = 1'b1;
          state_d = sts_i.last_digit ? S_IDLE : S_RD;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.out_err = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the base 2..10 radix converter.
`timescale 1ns / 100ps

module tb_top;
  import rbc_pkg::*;

  // Radix limits as the block is built here; the decimal radix splits the word.
  localparam int unsigned BASE_LIMIT   = 10;
  localparam int unsigned DEC_RADIX    = 10;
  localparam int unsigned DEC_COUNT    = 20;
  localparam int unsigned MAX_DIGITS   = 64;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS  = 64;
  localparam int unsigned HOLD_CYCLES  = 1200;
  localparam int unsigned DRAIN_CYCLES = 200;

  // One request, plus a typed-in result for rows whose answer is obvious.
  typedef struct packed {
    logic [3:0]        from_base;
    logic [3:0]        to_base;
    logic [WORD_W-1:0] word;
    logic              typed;
    logic [3:0]        digit;
    status_e           status;
  } req_row_t;

  // One emitted target digit as it appears on the result channel.
  typedef struct packed {
    logic [3:0] digit;
    status_e    status;
    logic       final_digit;
  } digit_item_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [3:0]        from_base_i;
  logic [3:0]        to_base_i;
  logic [WORD_W-1:0] digit_word_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [3:0]        out_digit_o;
  logic [1:0]        status_o;
  logic              last_o;

  // Digits still owed by the block, oldest first.
  digit_item_t pending_digits[$];
  int unsigned mismatches;

  // Idle and stall odds in percent, changed per phase by the stimulus.
  int unsigned idle_pct;
  int unsigned stall_pct;
  // Bump to ask the result side for one long hold-off.
  int unsigned hold_requests;

  radix_converter_base2_to_10_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .from_base_i  (from_base_i),
    .to_base_i    (to_base_i),
    .digit_word_i (digit_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_digit_o  (out_digit_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = ~clk_i;
  end

  // Work out the digits one request must produce and queue them, MSD first.
  // Check order: oversize source digit, then base range, then equal bases.
  function automatic void convert_word(input logic [3:0] fb, input logic [3:0] tb,
                                       input logic [WORD_W-1:0] word);
    logic [3:0]        dec [DEC_COUNT];
    logic [3:0]        tgt [MAX_DIGITS];
    logic [WORD_W-1:0] rest;
    logic [WORD_W-1:0] value;
    int                nd;
    int                nt;
    status_e           st;
    nd   = 0;
    nt   = 0;
    rest = word;
    st   = ST_OK;
    // Split into decimal digits, LSD first; zero still yields one digit.
    do begin
      dec[nd] = 4'(rest % WORD_W'(DEC_RADIX));
      rest    = rest / WORD_W'(DEC_RADIX);
      nd++;
    end while (rest != '0 && nd < DEC_COUNT);
    for (int i = 0; i < nd; i++) begin
      if (dec[i] >= fb) begin
        st = ST_DIGIT;
      end
    end
    if (st == ST_OK && (fb < MIN_BASE || fb > BASE_LIMIT ||
                        tb < MIN_BASE || tb > BASE_LIMIT)) begin
      st = ST_RANGE;
    end else if (st == ST_OK && fb == tb) begin
      st = ST_SAME;
    end
    if (st != ST_OK) begin
      pending_digits.push_back('{digit: 4'd0, status: st, final_digit: 1'b1});
      return;
    end
    // Horner's rule from the MSD; the 64-bit width wraps on its own.
    value = '0;
    for (int i = nd - 1; i >= 0; i--) begin
      value = value * WORD_W'(fb) + WORD_W'(dec[i]);
    end
    do begin
      tgt[nt] = 4'(value % WORD_W'(tb));
      value   = value / WORD_W'(tb);
      nt++;
    end while (value != '0 && nt < MAX_DIGITS);
    for (int i = 0; i < nt; i++) begin
      pending_digits.push_back('{digit: tgt[nt - 1 - i], status: ST_OK,
                                 final_digit: (i == nt - 1)});
    end
  endfunction

  // Build one random request. Most are well formed: legal, distinct bases
  // and a word whose decimal digits all fit the source base. The rest is
  // noise: random bases, fully random words, or one digit pushed too high.
  function automatic req_row_t random_request();
    req_row_t          r;
    logic [WORD_W-1:0] w;
    logic [3:0]        fb;
    logic [3:0]        tb;
    int unsigned       kind;
    int unsigned       sel;
    int unsigned       ndig;
    int unsigned       max_d;
    int                bad_pos;
    int unsigned       d;
    r    = '0;
    w    = '0;
    kind = $urandom_range(99);
    fb   = 4'($urandom_range(BASE_LIMIT, MIN_BASE));
    tb   = 4'($urandom_range(BASE_LIMIT, MIN_BASE));
    if (kind < 72 && tb == fb) begin
      tb = (fb == 4'(BASE_LIMIT)) ? 4'(MIN_BASE) : fb + 4'd1;
    end
    if (kind >= 72 && kind < 92) begin
      fb = 4'($urandom_range(15));
      tb = 4'($urandom_range(15));
    end
    max_d = (fb == 4'd0) ? 0 : ((fb > 4'(DEC_RADIX)) ? DEC_RADIX - 1 : fb - 1);
    // Keep most words short; long ones make long digit strings.
    sel  = $urandom_range(99);
    ndig = (sel < 55) ? $urandom_range(6, 1) :
           (sel < 93) ? $urandom_range(19, 7) : DEC_COUNT;
    bad_pos = -1;
    if (kind >= 92 && fb < 4'(DEC_RADIX)) begin
      bad_pos = $urandom_range(ndig - 1, (ndig == DEC_COUNT) ? 2 : 0);
    end
    for (int i = 0; i < ndig; i++) begin
      // A 20-digit word starts with 1 and then at most 7 to stay in range.
      if (ndig == DEC_COUNT && i == 0) begin
        d = 1;
      end else if (ndig == DEC_COUNT && i == 1) begin
        d = $urandom_range((max_d > 7) ? 7 : max_d);
      end else if (i == bad_pos) begin
        d = $urandom_range(DEC_RADIX - 1, fb);
      end else begin
        d = $urandom_range(max_d);
      end
      w = w * WORD_W'(DEC_RADIX) + WORD_W'(d);
    end
    if (kind >= 80 && kind < 92) begin
      w = {$urandom, $urandom};
    end
    r.from_base = fb;
    r.to_base   = tb;
    r.word      = w;
    return r;
  endfunction

  // Offer one request from the falling edge and hold it until accepted.
  // Valid stays high from one request into the next unless an idle cycle is drawn.
  task automatic send_request(input req_row_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    from_base_i  = r.from_base;
    to_base_i    = r.to_base;
    digit_word_i = r.word;
    in_valid_i   = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    // Accepted at this edge: queue what it must produce.
    if (r.typed) begin
      pending_digits.push_back('{digit: r.digit, status: r.status, final_digit: 1'b1});
    end else begin
      convert_word(r.from_base, r.to_base, r.word);
    end
  endtask

  // Directed rows: zero, single digits, the widest word, every error code and
  // the ordering of the checks. Typed rows carry their one obvious result.
  localparam req_row_t DIRECTED [24] = '{
    // zero gives a single digit 0, and a lone 1 stays 1
    '{4'd10, 4'd2,  64'd0,                    1'b1, 4'd0, ST_OK},
    '{4'd2,  4'd10, 64'd1,                    1'b1, 4'd1, ST_OK},
    // digit check runs before the range check: base 0 and base 1
    '{4'd0,  4'd5,  64'd0,                    1'b1, 4'd0, ST_DIGIT},
    '{4'd1,  4'd5,  64'd0,                    1'b1, 4'd0, ST_RANGE},
    '{4'd1,  4'd5,  64'd1,                    1'b1, 4'd0, ST_DIGIT},
    '{4'd8,  4'd3,  64'd19,                   1'b1, 4'd0, ST_DIGIT},
    '{4'd5,  4'd15, 64'd9,                    1'b1, 4'd0, ST_DIGIT},
    // base out of range on either side
    '{4'd15, 4'd2,  64'd123,                  1'b1, 4'd0, ST_RANGE},
    '{4'd10, 4'd11, 64'd5,                    1'b1, 4'd0, ST_RANGE},
    '{4'd10, 4'd0,  64'd5,                    1'b1, 4'd0, ST_RANGE},
    '{4'd10, 4'd15, 64'd99,                   1'b1, 4'd0, ST_RANGE},
    // equal bases
    '{4'd7,  4'd7,  64'd123,                  1'b1, 4'd0, ST_SAME},
    '{4'd10, 4'd10, 64'd0,                    1'b1, 4'd0, ST_SAME},
    // value below the target base
    '{4'd10, 4'd3,  64'd2,                    1'b1, 4'd2, ST_OK},
    '{4'd9,  4'd10, 64'd8,                    1'b1, 4'd8, ST_OK},
    '{4'd10, 4'd9,  64'd8,                    1'b1, 4'd8, ST_OK},
    '{4'd10, 4'd2,  64'd1,                    1'b1, 4'd1, ST_OK},
    // widest values, longest digit strings and a short base-3 word
    '{4'd10, 4'd2,  64'd18446744073709551615, 1'b0, 4'd0, ST_OK},
    '{4'd10, 4'd9,  64'd18446744073709551615, 1'b0, 4'd0, ST_OK},
    '{4'd10, 4'd2,  64'd10000000000000000000, 1'b0, 4'd0, ST_OK},
    '{4'd10, 4'd7,  64'd9999999999999999999,  1'b0, 4'd0, ST_OK},
    '{4'd2,  4'd10, 64'd1111111111111111111,  1'b0, 4'd0, ST_OK},
    '{4'd2,  4'd3,  64'd11111111111111111111, 1'b0, 4'd0, ST_OK},
    '{4'd3,  4'd8,  64'd12021,                1'b0, 4'd0, ST_OK}
  };

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = rst_ni && ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare every accepted digit against the oldest one owed.
  always @(posedge clk_i) begin
    digit_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_digits.size() == 0) begin
        mismatches++;
        $display("%0t: expected no digit, actual digit %0d status %0d last %0d", $time,
                 out_digit_o, status_o, last_o);
      end else begin
        exp_item = pending_digits.pop_front();
        if (out_digit_o !== exp_item.digit) begin
          mismatches++;
          $display("%0t: out_digit expected %0d actual %0d", $time,
                   exp_item.digit, out_digit_o);
        end
        if (status_o !== exp_item.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_item.status, status_o);
        end
        if (last_o !== exp_item.final_digit) begin
          mismatches++;
          $display("%0t: last expected %0d actual %0d", $time,
                   exp_item.final_digit, last_o);
        end
      end
    end
  end

  // Stimulus: reset, directed rows, then four random phases of idling and stalls.
  initial begin
    req_row_t r;
    mismatches    = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_requests = 0;
    in_valid_i    = 1'b0;
    from_base_i   = '0;
    to_base_i     = '0;
    digit_word_i  = '0;
    rst_ni        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i]);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          // Hold off the result side while requests keep coming.
          hold_requests++;
        end
        1: begin
          idle_pct  = 69;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 69;
        end
        default: begin
          idle_pct  = 37;
          stall_pct = 37;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = random_request();
        send_request(r);
      end
    end

    // Drop valid, drain what is owed, then watch for stray digits.
    @(negedge clk_i);
    in_valid_i = 1'b0;
    stall_pct  = 0;
    while (pending_digits.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
